>>> sv/ssd_pkg.sv
// Shared types, constants and font table of the seven-segment scan driver.
package ssd_pkg;

   localparam int SYMBOL_W    = 8;
   localparam int PATTERN_W   = 8;
   localparam int SELECT_W    = 3;
   localparam int POSITION_W  = 2;
   localparam int BEAT_CNT_W  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [BEAT_CNT_W-1:0] LATCH_BEAT = 4'd8;

   localparam logic [PATTERN_W-1:0] GLYPH_UNKNOWN = 8'hF5;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [SELECT_W-1:0]  select;
   } glyph_entry_type;

   // Segment pattern for one ASCII code; bit 0 is segment a, bit 7 the dot.
   function automatic logic [PATTERN_W-1:0] glyph_of(input logic [SYMBOL_W-1:0] code);
      logic [PATTERN_W-1:0] pat;
      unique case (code)
         8'h61:   pat = 8'h77; // a
         8'h62:   pat = 8'h7A; // b
         8'h63:   pat = 8'h69; // c
         8'h64:   pat = 8'h3E; // d
         8'h65:   pat = 8'h79; // e
         8'h66:   pat = 8'h71; // f
         8'h30:   pat = 8'h6F; // 0
         8'h31:   pat = 8'h06; // 1
         8'h32:   pat = 8'h3D; // 2
         8'h33:   pat = 8'h1F; // 3
         8'h34:   pat = 8'h56; // 4
         8'h35:   pat = 8'h5B; // 5
         8'h36:   pat = 8'h7B; // 6
         8'h37:   pat = 8'h07; // 7
         8'h38:   pat = 8'h7F; // 8
         8'h39:   pat = 8'h5F; // 9
         8'h2E:   pat = 8'h80; // dot
         default: pat = GLYPH_UNKNOWN;
      endcase
      return pat;
   endfunction

endpackage

>>> sv/ssd_front.sv
// Front end: accepts characters, looks up the glyph and tags the digit select.
module ssd_front #(
   parameter int NUM_DIGITS = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ssd_pkg::SYMBOL_W-1:0]     req_tdata,
   output logic                             push,
   output ssd_pkg::glyph_entry_type         push_entry,
   input  logic                             queue_full
);
   import ssd_pkg::*;

   logic [POSITION_W-1:0] position_ff;
   logic [POSITION_W-1:0] position_in;
   logic [3:0]            onehot;
   logic [3:0]            next_pos;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // A position past the select field drives no digit.
   assign onehot             = 4'b0001 << position_ff;
   assign push_entry.select  = onehot[SELECT_W-1:0];
   assign push_entry.pattern = glyph_of(req_tdata);

   always_comb begin
      next_pos    = {2'b00, position_ff} + 4'd1;
      position_in = position_ff;
      if (push) begin
         if (next_pos >= 4'(NUM_DIGITS) || next_pos > 4'd3) begin
            position_in = '0;
         end else begin
            position_in = next_pos[POSITION_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

endmodule

>>> sv/ssd_queue.sv
// Two-entry queue of glyph entries between the front and back ends.
module ssd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ssd_pkg::glyph_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output ssd_pkg::glyph_entry_type pop_entry
);
   import ssd_pkg::*;

   glyph_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/ssd_back.sv
// Back end: serializes one glyph into eight shift beats and one latch beat.
module ssd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_not_empty,
   input  ssd_pkg::glyph_entry_type queue_entry,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);
   import ssd_pkg::*;

   logic                        busy_ff, busy_in;
   logic [BEAT_CNT_W-1:0]       beat_ff, beat_in;
   glyph_entry_type             cur_ff, cur_in;
   logic                        is_latch;
   logic                        fire;
   logic [2:0]                  bit_idx;
   logic                        data_bit;

   assign is_latch = (beat_ff == LATCH_BEAT);
   assign fire     = busy_ff && rsp_tready;
   assign pop      = queue_not_empty && (!busy_ff || (fire && is_latch));

   // Most significant pattern bit goes out first.
   assign bit_idx  = ~beat_ff[2:0];
   assign data_bit = is_latch ? 1'b0 : cur_ff.pattern[bit_idx];

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {4'b0000, cur_ff.select, data_bit};
   assign rsp_tuser  = {is_latch, !is_latch};
   assign rsp_tlast  = is_latch;

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      cur_in  = cur_ff;
      if (pop) begin
         busy_in = 1'b1;
         beat_in = '0;
         cur_in  = queue_entry;
      end else if (fire) begin
         if (is_latch) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

endmodule

>>> sv/seven_segment_serial_scan_driver_unit.sv
// Top level of the seven-segment serial scan driver.
//
// Each character beat on the req side becomes nine rsp beats for a
// 74HC595-style shift register: eight shift beats carrying the segment
// pattern most significant bit first (dot first, segment a last), then one
// latch beat that has tlast set. Lowercase hex digits, 0-9 and dot have
// their own glyphs; every other code shows pattern 8'hF5. All nine beats
// carry the one-hot select of the current digit, which advances after
// every character and wraps after NUM_DIGITS characters (or after the
// fourth position, which drives no select bit). The back-end serializer
// emits one beat per cycle while rsp_tready is held high, and takes the
// next character from the queue with the latch beat of the current one.
// With the serializer idle, a taken character is written into the queue,
// then popped into the serializer's glyph register, and rsp_tvalid for the
// first beat rises with the busy flag set by that pop. A two-entry queue
// lets the front keep taking characters while the serializer stalls.
module seven_segment_serial_scan_driver_unit #(
   parameter int NUM_DIGITS = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] serial_data, [3:1] digit_select, [7:4] zero
   output logic [1:0] rsp_tuser,   // [0] shift_pulse, [1] latch_pulse
   output logic       rsp_tlast    // last: latch beat of a character
);
   import ssd_pkg::*;

   logic            push;
   glyph_entry_type push_entry;
   logic            queue_full;
   logic            pop;
   logic            queue_not_empty;
   glyph_entry_type pop_entry;

   // Classify the character and tag it with the digit it lands on.
   ssd_front #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Decouple front and back so either side can stall alone.
   ssd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .pop_entry  (pop_entry)
   );

   // Shift out the glyph and latch it.
   ssd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_entry     (pop_entry),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

endmodule
